@@ rtl/core/upe_pkg.sv @@
// Shared types, constants and character helpers for the URI percent encoder.
package upe_pkg;

  localparam int MAX_SEQUENCE_DEF = 6;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [7:0] ASCII_PCT  = 8'h25;
  localparam logic [7:0] ASCII_MAX  = 8'd127;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_HEX,
    CMD_STATUS
  } cmd_kind_t;

  typedef enum logic {
    FRONT_ACCEPT,
    FRONT_DUMP
  } front_state_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
  } cmd_t;

  function automatic logic passes_through(input logic [7:0] b);
    logic alnum;
    logic mark;
    alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
            (b >= 8'h61 && b <= 8'h7a);
    mark  = (b == 8'h2d) || (b == 8'h5f) || (b == 8'h2e) || (b == 8'h21) ||
            (b == 8'h7e) || (b == 8'h2a) || (b == 8'h27) || (b == 8'h28) ||
            (b == 8'h29);
    return alnum || mark;
  endfunction

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= 8'd192 && b <= 8'd223)      len = 3'd2;
    else if (b >= 8'd224 && b <= 8'd239) len = 3'd3;
    else if (b >= 8'd240 && b <= 8'd247) len = 3'd4;
    else if (b >= 8'd248 && b <= 8'd251) len = 3'd5;
    else if (b >= 8'd252 && b <= 8'd253) len = 3'd6;
    return len;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) ch = 8'h30 + {4'b0, nib};
    else             ch = 8'h57 + {4'b0, nib};
    return ch;
  endfunction

endpackage

@@ rtl/core/uri_percent_encoder_unit.sv @@
// Top level of the URI percent encoder: front end, command queue, character emitter.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_byte, end_of_string
//   out      output     out_valid/out_stall out_char, has_char, last, status
//
// The front end takes one byte per cycle while the queue has room and no sequence is
// being replayed. The back end emits one character per cycle while out_stall is low:
// a pass-through byte gives one character, an escaped byte three, and a completed n-byte
// UTF-8 sequence 3n characters, replayed by the front end with in_stall high meanwhile.
// Reset clears sequence, halt and queue state at once; no clearing pass.
// out_stall holds the output register; the 4-entry queue lets input continue meanwhile.
module uri_percent_encoder_unit import upe_pkg::*; #(
  parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       has_char,
  output logic       last,
  output logic [1:0] status
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_cmd;
  cmd_t q_head;

  upe_front #(.MAX_SEQUENCE(MAX_SEQUENCE)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  upe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  upe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .has_char  (has_char),
    .last      (last),
    .status    (status)
  );

endmodule

@@ rtl/core/upe_front.sv @@
// Front end: accepts bytes, tracks UTF-8 sequences and halt state, queues encode commands.
module upe_front import upe_pkg::*; #(
  parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam int BufDepth = MAX_SEQUENCE - 1;
  localparam int IdxW     = (BufDepth > 1) ? $clog2(BufDepth) : 1;

  front_state_t state, state_next;
  logic [2:0]   seq_len, seq_len_next;
  logic [2:0]   seq_filled, seq_filled_next;
  logic [2:0]   dump_idx, dump_idx_next;
  logic         halted, halted_next;
  logic [1:0]   halt_status, halt_status_next;
  logic [7:0]   final_byte;
  logic         final_eos;
  logic [7:0]   seq_buf [BufDepth];
  logic         buf_we;
  logic [IdxW-1:0] buf_wi;
  logic [2:0]   lead_len;
  logic         take;

  assign in_stall = (state != FRONT_ACCEPT) || q_full;
  assign take     = in_valid && !in_stall;
  assign lead_len = lead_length(in_byte);

  always_comb begin
    state_next       = state;
    seq_len_next     = seq_len;
    seq_filled_next  = seq_filled;
    dump_idx_next    = dump_idx;
    halted_next      = halted;
    halt_status_next = halt_status;
    buf_we           = 1'b0;
    buf_wi           = seq_filled[IdxW-1:0];
    q_push           = 1'b0;
    q_cmd            = '{kind: CMD_CHAR, data: in_byte, last: end_of_string, status: ST_OK};
    unique case (state)
      FRONT_ACCEPT: begin
        if (take) begin
          if (halted) begin
            if (end_of_string) begin
              q_push           = 1'b1;
              q_cmd            = '{kind: CMD_STATUS, data: 8'd0, last: 1'b1,
                                   status: halt_status};
              halted_next      = 1'b0;
              halt_status_next = ST_OK;
              seq_len_next     = 3'd0;
              seq_filled_next  = 3'd0;
            end
          end else if (seq_len != 3'd0) begin
            if ((seq_filled + 3'd1) >= seq_len) begin
              // sequence complete: replay buffer, then this byte
              state_next    = FRONT_DUMP;
              dump_idx_next = 3'd0;
            end else begin
              buf_we          = 1'b1;
              seq_filled_next = seq_filled + 3'd1;
              if (end_of_string) begin
                q_push          = 1'b1;
                q_cmd           = '{kind: CMD_STATUS, data: 8'd0, last: 1'b1,
                                    status: ST_TRUNC};
                seq_len_next    = 3'd0;
                seq_filled_next = 3'd0;
              end
            end
          end else if (passes_through(in_byte)) begin
            q_push = 1'b1;
          end else if (in_byte <= ASCII_MAX) begin
            q_push     = 1'b1;
            q_cmd.kind = CMD_HEX;
          end else if (lead_len == 3'd0 || lead_len > 3'(MAX_SEQUENCE)) begin
            if (end_of_string) begin
              q_push = 1'b1;
              q_cmd  = '{kind: CMD_STATUS, data: 8'd0, last: 1'b1, status: ST_INVALID};
            end else begin
              halted_next      = 1'b1;
              halt_status_next = ST_INVALID;
            end
          end else begin
            buf_we          = 1'b1;
            buf_wi          = '0;
            seq_len_next    = lead_len;
            seq_filled_next = 3'd1;
            if (end_of_string) begin
              q_push          = 1'b1;
              q_cmd           = '{kind: CMD_STATUS, data: 8'd0, last: 1'b1,
                                  status: ST_TRUNC};
              seq_len_next    = 3'd0;
              seq_filled_next = 3'd0;
            end
          end
        end
      end
      FRONT_DUMP: begin
        if (!q_full) begin
          q_push = 1'b1;
          if (dump_idx == seq_filled) begin
            q_cmd           = '{kind: CMD_HEX, data: final_byte, last: final_eos,
                                status: ST_OK};
            state_next      = FRONT_ACCEPT;
            seq_len_next    = 3'd0;
            seq_filled_next = 3'd0;
          end else begin
            q_cmd         = '{kind: CMD_HEX, data: seq_buf[dump_idx[IdxW-1:0]], last: 1'b0,
                              status: ST_OK};
            dump_idx_next = dump_idx + 3'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= FRONT_ACCEPT;
      seq_len     <= 3'd0;
      seq_filled  <= 3'd0;
      dump_idx    <= 3'd0;
      halted      <= 1'b0;
      halt_status <= ST_OK;
    end else begin
      state       <= state_next;
      seq_len     <= seq_len_next;
      seq_filled  <= seq_filled_next;
      dump_idx    <= dump_idx_next;
      halted      <= halted_next;
      halt_status <= halt_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      final_byte <= in_byte;
      final_eos  <= end_of_string;
    end
    if (buf_we) begin
      seq_buf[buf_wi] <= in_byte;
    end
  end

`ifndef SYNTH
  a_dump_stalls: assert property (@(posedge clk) disable iff (rst)
    state == FRONT_DUMP |-> in_stall)
    else $error("input taken while replaying a sequence");
`endif

endmodule

@@ rtl/core/upe_queue.sv @@
// Short command queue between the front end and the character emitter.
module upe_queue import upe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  cmd_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign full  = (count == (PtrW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + PtrW'(1);
      if (push && !pop)      count <= count + (PtrW+1)'(1);
      else if (pop && !push) count <= count - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

@@ rtl/core/upe_back.sv @@
// Back end: expands queued commands into output characters, one per cycle unless stalled.
module upe_back import upe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       has_char,
  output logic       last,
  output logic [1:0] status
);

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] phase;

  cmd_t       src;
  logic [1:0] src_phase;
  logic       load;
  logic       emit;
  logic       fin;
  logic [7:0] ch;
  logic       ch_has;
  logic       ch_last;
  logic [1:0] ch_status;

  assign load      = !out_valid || !out_stall;
  assign src       = cur_valid ? cur : q_head;
  assign src_phase = cur_valid ? phase : 2'd0;
  assign emit      = load && (cur_valid || !q_empty);
  assign q_pop     = emit && !cur_valid;

  always_comb begin
    ch        = 8'd0;
    ch_has    = 1'b1;
    ch_last   = src.last;
    ch_status = ST_OK;
    fin       = 1'b1;
    unique case (src.kind)
      CMD_CHAR: begin
        ch = src.data;
      end
      CMD_HEX: begin
        priority if (src_phase == 2'd0) ch = ASCII_PCT;
        else if (src_phase == 2'd1)     ch = hex_digit(src.data[7:4]);
        else                            ch = hex_digit(src.data[3:0]);
        fin     = (src_phase == 2'd2);
        ch_last = src.last && fin;
      end
      CMD_STATUS: begin
        ch_has    = 1'b0;
        ch_last   = 1'b1;
        ch_status = src.status;
      end
      default: begin
        ch_has  = 1'b0;
        ch_last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      phase     <= 2'd0;
    end else if (emit) begin
      out_valid <= 1'b1;
      if (fin) begin
        cur_valid <= 1'b0;
        phase     <= 2'd0;
      end else begin
        cur_valid <= 1'b1;
        phase     <= src_phase + 2'd1;
      end
    end else if (load) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cur      <= src;
      out_char <= ch;
      has_char <= ch_has;
      last     <= ch_last;
      status   <= ch_status;
    end
  end

`ifndef SYNTH
  a_char_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_char |-> status == ST_OK)
    else $error("character transaction with nonzero status");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> last)
    else $error("status-only transaction without last");
`endif

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the URI percent encoder: random strings, stalls and a checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import upe_pkg::*;

  localparam int         LIMIT_CYCLES = 200000;
  localparam int         SEQ_DEPTH    = MAX_SEQUENCE_DEF - 1;
  localparam logic [7:0] SPACE_CH     = 8'h20;
  localparam logic [8*9-1:0] MARK_CHARS = "-_.!~*'()";

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } str_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
    logic [1:0] st;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       has_char;
  logic       out_last;
  logic [1:0] status;

  str_byte_t  byte_q[$];
  enc_char_t  enc_exp_q[$];
  str_byte_t  nxt;
  enc_char_t  got;
  enc_char_t  want;

  // encoder state as predicted
  logic [7:0] seq_buf[SEQ_DEPTH];
  logic [2:0] seq_len = 3'd0;
  logic [2:0] seq_fill = 3'd0;
  logic       halted = 1'b0;
  logic [1:0] halt_st = ST_OK;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int n_useful = 0;
  int n_in = 0;
  int n_strings = 0;
  int n_out = 0;
  int n_trunc = 0;
  int n_inval = 0;
  int n_fail = 0;
  int cycles = 0;

  uri_percent_encoder_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .has_char     (has_char),
    .last         (out_last),
    .status       (status)
  );

  always #1 clk = ~clk;

  function automatic logic is_plain(input logic [7:0] b);
    logic hit;
    hit = (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    for (int i = 0; i < 9; i++)
      if (b == MARK_CHARS[8*i +: 8]) hit = 1'b1;
    return hit;
  endfunction

  function automatic logic [2:0] utf8_span(input logic [7:0] b);
    if (b >= 8'd192 && b <= 8'd223) return 3'd2;
    if (b >= 8'd224 && b <= 8'd239) return 3'd3;
    if (b >= 8'd240 && b <= 8'd247) return 3'd4;
    if (b >= 8'd248 && b <= 8'd251) return 3'd5;
    if (b >= 8'd252 && b <= 8'd253) return 3'd6;
    return 3'd0;
  endfunction

  function automatic logic [7:0] nib_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'b0, n} : 8'h61 + {4'b0, n} - 8'd10;
  endfunction

  function automatic void expect_char(input logic [7:0] c);
    enc_char_t e;
    e = '{ch: c, has: 1'b1, last: 1'b0, st: ST_OK};
    enc_exp_q.insert(enc_exp_q.size(), e);
  endfunction

  function automatic void expect_hex(input logic [7:0] b);
    expect_char(ASCII_PCT);
    expect_char(nib_char(b[7:4]));
    expect_char(nib_char(b[3:0]));
  endfunction

  function automatic void expect_status(input logic [1:0] st);
    enc_char_t e;
    e = '{ch: 8'h00, has: 1'b0, last: 1'b1, st: st};
    enc_exp_q.insert(enc_exp_q.size(), e);
  endfunction

  // Advance the predicted state by one accepted byte and queue what it produces.
  function automatic void encode_byte(input logic [7:0] b, input logic eos);
    int        first;
    bit        done;
    logic [2:0] span;
    enc_char_t tmp;
    first = enc_exp_q.size();
    done  = 1'b0;
    if (halted) begin
      if (eos) begin
        expect_status(halt_st);
        halted   = 1'b0;
        halt_st  = ST_OK;
        seq_len  = 3'd0;
        seq_fill = 3'd0;
      end
      done = 1'b1;
    end else if (seq_len != 3'd0) begin
      if ({1'b0, seq_fill} + 4'd1 >= {1'b0, seq_len}) begin
        for (int i = 0; i < seq_fill; i++) expect_hex(seq_buf[i]);
        expect_hex(b);
        seq_len  = 3'd0;
        seq_fill = 3'd0;
      end else begin
        seq_buf[seq_fill] = b;
        seq_fill = seq_fill + 3'd1;
      end
    end else if (is_plain(b)) begin
      expect_char(b);
    end else if (b == SPACE_CH) begin
      expect_char(ASCII_PCT);
      expect_char("2");
      expect_char("0");
    end else if (b <= ASCII_MAX) begin
      expect_hex(b);
    end else begin
      span = utf8_span(b);
      if (span == 3'd0 || span > MAX_SEQUENCE_DEF) begin
        if (eos) expect_status(ST_INVALID);
        else begin
          halted  = 1'b1;
          halt_st = ST_INVALID;
        end
        done = 1'b1;
      end else begin
        seq_buf[0] = b;
        seq_fill   = 3'd1;
        seq_len    = span;
      end
    end
    if (!done && eos) begin
      if (seq_len != 3'd0) begin
        seq_len  = 3'd0;
        seq_fill = 3'd0;
        expect_status(ST_TRUNC);
      end else if (enc_exp_q.size() > first) begin
        tmp = enc_exp_q[enc_exp_q.size() - 1];
        tmp.last = 1'b1;
        enc_exp_q[enc_exp_q.size() - 1] = tmp;
      end
    end
  endfunction

  // Driver: offer bytes from the pending queue, hold the payload while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_byte(in_byte, end_of_string);
        n_in++;
        if (end_of_string) n_strings++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
          nxt = byte_q.pop_front();
          in_valid      <= 1'b1;
          in_byte       <= nxt.b;
          end_of_string <= nxt.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(input string fname, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Monitor: check each output transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{ch: out_char, has: has_char, last: out_last, st: status};
        n_out++;
        if (status == ST_TRUNC) n_trunc++;
        if (status == ST_INVALID) n_inval++;
        if (enc_exp_q.size() == 0) begin
          $display("%0t: unexpected output, expected none, got char %h has %b last %b status %0d",
                   $time, got.ch, got.has, got.last, got.st);
          n_fail++;
        end else begin
          want = enc_exp_q.pop_front();
          cmp_field("out_char", want.ch, got.ch);
          cmp_field("has_char", {7'b0, want.has}, {7'b0, got.has});
          cmp_field("last", {7'b0, want.last}, {7'b0, got.last});
          cmp_field("status", {6'b0, want.st}, {6'b0, got.st});
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 23);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, enc_exp_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eos, input bit counts);
    str_byte_t item;
    item = '{b: b, eos: eos};
    while (byte_q.size() > 8) @(posedge clk);
    byte_q.insert(byte_q.size(), item);
    if (counts) n_useful++;
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (enc_exp_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_tail();
    return ($urandom_range(3) != 0) ? 8'($urandom_range(128, 191)) : 8'($urandom_range(1, 255));
  endfunction

  // Build one random string: mostly well formed, some cut short or broken.
  task automatic push_random_string();
    int         pieces, mode, kind, cut;
    logic [2:0] span;
    logic [7:0] b;
    bit         fin;
    pieces = $urandom_range(1, 8);
    mode   = $urandom_range(99);
    for (int p = 0; p < pieces; p++) begin
      fin  = (mode < 82) && (p == pieces - 1);
      kind = $urandom_range(99);
      if (kind < 25) begin
        b    = 8'($urandom_range(192, 253));
        span = utf8_span(b);
        push_byte(b, 1'b0, 1'b1);
        for (int j = 1; j < span; j++) push_byte(rand_tail(), fin && (j == span - 1), 1'b1);
      end else if (kind < 35) begin
        push_byte(SPACE_CH, fin, 1'b1);
      end else if (kind < 50) begin
        push_byte(MARK_CHARS[8*$urandom_range(8) +: 8], fin, 1'b1);
      end else begin
        push_byte(8'($urandom_range(1, 127)), fin, 1'b1);
      end
    end
    if (mode >= 82 && mode < 91) begin
      b    = 8'($urandom_range(192, 253));
      span = utf8_span(b);
      cut  = $urandom_range(0, span - 2);
      push_byte(b, cut == 0, 1'b1);
      for (int j = 1; j <= cut; j++) push_byte(rand_tail(), j == cut, 1'b1);
    end else if (mode >= 91) begin
      case ($urandom_range(2))
        0:       b = 8'($urandom_range(128, 191));
        1:       b = 8'hfe;
        default: b = 8'hff;
      endcase
      cut = $urandom_range(0, 3);
      push_byte(b, cut == 0, 1'b1);
      // everything after the bad byte is dropped by the block
      for (int j = 1; j <= cut; j++) push_byte(8'($urandom_range(1, 255)), j == cut, 1'b0);
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // control byte, letter, space, mark
    push_byte(8'h01, 1'b0, 1'b1);
    push_byte("Z", 1'b0, 1'b1);
    push_byte(SPACE_CH, 1'b0, 1'b1);
    push_byte("~", 1'b1, 1'b1);
    // zero byte and top of ASCII
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'h7f, 1'b1, 1'b1);
    // smallest two-byte sequence
    push_byte(8'hc0, 1'b0, 1'b1);
    push_byte(8'ha9, 1'b1, 1'b1);
    // six-byte sequence with arbitrary content
    push_byte(8'hfd, 1'b0, 1'b1);
    push_byte(8'hff, 1'b0, 1'b1);
    push_byte(8'h01, 1'b0, 1'b1);
    push_byte(8'h80, 1'b0, 1'b1);
    push_byte("A", 1'b0, 1'b1);
    push_byte(8'hbf, 1'b1, 1'b1);
    // truncated on the lead byte, then truncated mid-sequence
    push_byte(8'he2, 1'b1, 1'b1);
    push_byte(8'hf0, 1'b0, 1'b1);
    push_byte(8'h9f, 1'b1, 1'b1);
    // stray continuation halts the string
    push_byte(8'h80, 1'b0, 1'b1);
    push_byte("a", 1'b0, 1'b0);
    push_byte("b", 1'b1, 1'b0);
    // invalid bytes at end and mid-string
    push_byte(8'hff, 1'b1, 1'b1);
    push_byte(8'hbf, 1'b1, 1'b1);
    push_byte(8'hfe, 1'b0, 1'b1);
    push_byte("(", 1'b1, 1'b0);
    drain();

    while (n_useful < 300) begin
      calm = (n_useful >= 150 && n_useful < 220);
      if (n_useful >= 260) hold_req = 1'b1;
      if (n_useful >= 90 && !paused) begin
        paused = 1'b1;
        drain();
      end
      push_random_string();
    end
    calm = 1'b0;
    drain();
    repeat (40) @(posedge clk);

    $display("Covered %0d strings, %0d bytes in, %0d output transactions", n_strings, n_in,
             n_out);
    $display("Status-only results: %0d truncated, %0d invalid; %0d mismatches", n_trunc,
             n_inval, n_fail);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ uri_percent_encoder_unit.f @@
rtl/core/upe_pkg.sv
rtl/core/upe_front.sv
rtl/core/upe_queue.sv
rtl/core/upe_back.sv
rtl/core/uri_percent_encoder_unit.sv
dv/tb_top.sv
